### design/qvr_pkg.sv
// Shared constants for the quaternion vector rotation block.
// Holds quaternion widths, register indexes and reset values; no dependencies.
package qvr_pkg;

  // Quaternion components are signed Q2.14.
  localparam int unsigned QUAT_W  = 16;
  // Product of two quaternion components.
  localparam int unsigned QPROD_W = 2 * QUAT_W;
  // Matrix entries are signed sums of four products or twice a sum of two.
  localparam int unsigned MAT_W   = QPROD_W + 2;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_QUAT_SCALAR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_VEC_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_VEC_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_VEC_Z  = 3'd3;

  // 1.0 in Q2.14.
  localparam logic signed [QUAT_W-1:0] QUAT_ONE  = 16'sd16384;
  localparam logic signed [QUAT_W-1:0] QUAT_ZERO = 16'sd0;

  // Cycles the matrix registers need to follow the quaternion registers.
  localparam int unsigned  SETTLE_W     = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 2'd2;
  localparam logic [SETTLE_W-1:0] SETTLE_WRITE = 2'd1;

endpackage

### design/quaternion_vector_rotate_top.sv
// Quaternion rotation of a 3D point stream: vector part of q*(0,v)*conj(q).
// Throughput one point per cycle while out_ready_i is high and no matrix settle is pending.
// The four pipeline stages are input register, matrix-by-point multiply, sum with rounding
// bias, and shift with saturation.
// Reset (asynchronous, active low) loads q = 1.0 and empties the pipeline; input ready stays
// low after reset and after a register write while the matrix settles.
module quaternion_vector_rotate_top #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned FRAC_BITS   = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qvr_pkg::QUAT_W-1:0]         cfg_wdata_i,
  // Input point channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]      point_x_i,
  input  logic signed [COORD_WIDTH-1:0]      point_y_i,
  input  logic signed [COORD_WIDTH-1:0]      point_z_i,
  // Rotated point channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [COORD_WIDTH-1:0]      rot_x_o,
  output logic signed [COORD_WIDTH-1:0]      rot_y_o,
  output logic signed [COORD_WIDTH-1:0]      rot_z_o,
  output logic                               saturated_o
);
  import qvr_pkg::*;

  // Each product of a matrix entry and a coordinate.
  localparam int unsigned PROD_W = MAT_W + COORD_WIDTH;
  // The accumulator holds the sum of three products plus the rounding bias.
  localparam int unsigned ACC_A  = PROD_W + 2;
  localparam int unsigned ACC_B  = 2 * FRAC_BITS + 2;
  localparam int unsigned ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
  // The matrix carries two quaternion factors, so the result is scaled by 2^(2*FRAC_BITS).
  localparam int unsigned SH     = 2 * FRAC_BITS;

  localparam logic signed [ACC_W-1:0] RndBias =
    {{(ACC_W-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [ACC_W-1:0] SatMax =
    {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SatMin =
    {{(ACC_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Quaternion registers and the rotation matrix derived from them.
  // The matrix is R = (s^2 - |u|^2) I + 2 u u^T + 2 s [u]x, built in two register
  // steps: component products first, then the sums. The user must only change
  // configuration while the pipeline is empty; the block does not enforce it. Given
  // that, a short settle counter holding input ready low is all the matrix needs.
  // ---------------------------------------------------------------------------
  logic signed [QUAT_W-1:0] qs_q, qx_q, qy_q, qz_q;
  logic [SETTLE_W-1:0]      settle_q, settle_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_q     <= QUAT_ONE;
      qx_q     <= QUAT_ZERO;
      qy_q     <= QUAT_ZERO;
      qz_q     <= QUAT_ZERO;
      settle_q <= SETTLE_RESET;
    end else begin
      settle_q <= settle_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_QUAT_SCALAR: qs_q <= cfg_wdata_i;
          REG_QUAT_VEC_X:  qx_q <= cfg_wdata_i;
          REG_QUAT_VEC_Y:  qy_q <= cfg_wdata_i;
          REG_QUAT_VEC_Z:  qz_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (cfg_we_i) begin
      settle_d = SETTLE_WRITE;
    end else if (settle_q != '0) begin
      settle_d = settle_q - SETTLE_W'(1);
    end else begin
      settle_d = settle_q;
    end
  end

  logic signed [QPROD_W-1:0] pss_q, pxx_q, pyy_q, pzz_q;
  logic signed [QPROD_W-1:0] pxy_q, pxz_q, pyz_q, psx_q, psy_q, psz_q;
  logic signed [MAT_W-1:0]   mat_d [3][3];
  logic signed [MAT_W-1:0]   mat_q [3][3];

  always_ff @(posedge clk_i) begin
    pss_q <= QPROD_W'(qs_q) * QPROD_W'(qs_q);
    pxx_q <= QPROD_W'(qx_q) * QPROD_W'(qx_q);
    pyy_q <= QPROD_W'(qy_q) * QPROD_W'(qy_q);
    pzz_q <= QPROD_W'(qz_q) * QPROD_W'(qz_q);
    pxy_q <= QPROD_W'(qx_q) * QPROD_W'(qy_q);
    pxz_q <= QPROD_W'(qx_q) * QPROD_W'(qz_q);
    pyz_q <= QPROD_W'(qy_q) * QPROD_W'(qz_q);
    psx_q <= QPROD_W'(qs_q) * QPROD_W'(qx_q);
    psy_q <= QPROD_W'(qs_q) * QPROD_W'(qy_q);
    psz_q <= QPROD_W'(qs_q) * QPROD_W'(qz_q);
  end

  always_comb begin
    mat_d[0][0] = MAT_W'(pss_q) + MAT_W'(pxx_q) - MAT_W'(pyy_q) - MAT_W'(pzz_q);
    mat_d[1][1] = MAT_W'(pss_q) - MAT_W'(pxx_q) + MAT_W'(pyy_q) - MAT_W'(pzz_q);
    mat_d[2][2] = MAT_W'(pss_q) - MAT_W'(pxx_q) - MAT_W'(pyy_q) + MAT_W'(pzz_q);
    mat_d[0][1] = (MAT_W'(pxy_q) - MAT_W'(psz_q)) <<< 1;
    mat_d[0][2] = (MAT_W'(pxz_q) + MAT_W'(psy_q)) <<< 1;
    mat_d[1][0] = (MAT_W'(pxy_q) + MAT_W'(psz_q)) <<< 1;
    mat_d[1][2] = (MAT_W'(pyz_q) - MAT_W'(psx_q)) <<< 1;
    mat_d[2][0] = (MAT_W'(pxz_q) - MAT_W'(psy_q)) <<< 1;
    mat_d[2][1] = (MAT_W'(pyz_q) + MAT_W'(psx_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    mat_q <= mat_d;
  end

  // ---------------------------------------------------------------------------
  // Point pipeline. Each stage loads when it is empty or the stage after it
  // moves, so a stall at the output backs up stage by stage without losing or
  // repeating a transaction.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o = rdy1 && (settle_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i && in_ready_o;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: input register.
  logic signed [COORD_WIDTH-1:0] pt_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pt_q[0] <= point_x_i;
      pt_q[1] <= point_y_i;
      pt_q[2] <= point_z_i;
    end
  end

  // Stage 2: the nine matrix-by-coordinate products.
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = PROD_W'(mat_q[i][j]) * PROD_W'(pt_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) prod_q <= prod_d;
  end

  // Stage 3: row sums with the half-LSB bias for round to nearest, ties up.
  logic signed [ACC_W-1:0] acc_d [3];
  logic signed [ACC_W-1:0] acc_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = ACC_W'(prod_q[i][0]) + ACC_W'(prod_q[i][1]) + ACC_W'(prod_q[i][2])
                 + RndBias;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) acc_q <= acc_d;
  end

  // Stage 4: drop the fraction (floor) and clip to the coordinate range.
  logic signed [ACC_W-1:0]       shr    [3];
  logic signed [COORD_WIDTH-1:0] rot_d  [3];
  logic signed [COORD_WIDTH-1:0] rot_q  [3];
  logic [2:0]                    clip;
  logic                          sat_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shr[i] = acc_q[i] >>> SH;
      if (shr[i] > SatMax) begin
        rot_d[i] = SatMax[COORD_WIDTH-1:0];
        clip[i]  = 1'b1;
      end else if (shr[i] < SatMin) begin
        rot_d[i] = SatMin[COORD_WIDTH-1:0];
        clip[i]  = 1'b1;
      end else begin
        rot_d[i] = shr[i][COORD_WIDTH-1:0];
        clip[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      rot_q <= rot_d;
      sat_q <= |clip;
    end
  end

  assign out_valid_o = v4_q;
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign saturated_o = sat_q;

endmodule
